// ----- rtl/priority_interrupt_controller_core_defines.svh -----
// ----------------------------------------------------------------------------
// priority interrupt controller assertion macros
// shared concurrent assertion forms, clocked on clk, held off during reset
// ----------------------------------------------------------------------------
`ifndef PRIORITY_INTERRUPT_CONTROLLER_CORE_DEFINES_SVH
`define PRIORITY_INTERRUPT_CONTROLLER_CORE_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define PIC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define PIC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/pic_pkg.sv -----
// ----------------------------------------------------------------------------
// pic_pkg
// types, constants and selection helpers of the priority interrupt controller
// ----------------------------------------------------------------------------
`default_nettype none

package pic_pkg;

  // configuration defaults and field widths
  localparam int NUM_LINES_DEF = 64;
  localparam int OPCODE_W      = 4;
  localparam int LINE_NUM_W    = 8;
  localparam int PRIO_W        = 4;
  localparam int GRANT_W       = 6;
  localparam int IN_TDATA_W    = 16;
  localparam int OUT_TDATA_W   = 16;
  localparam int OUT_PAD_W     = OUT_TDATA_W - (1 + PRIO_W + 1 + GRANT_W);

  // least urgent priority, also the reset value and the out-of-range read
  localparam logic [PRIO_W-1:0] PRIO_MAX = 4'd15;

  // selection tree: lines are reduced in groups, then group winners
  localparam int GROUP_SIZE = 16;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ENABLE    = 4'd0,
    OP_DISABLE   = 4'd1,
    OP_SET_PEND  = 4'd2,
    OP_CLR_PEND  = 4'd3,
    OP_READ_PEND = 4'd4,
    OP_SET_PRIO  = 4'd5,
    OP_READ_PRIO = 4'd6,
    OP_ACK       = 4'd7,
    OP_END       = 4'd8
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FINAL
  } state_t;

  // one contender in the priority tree
  typedef struct packed {
    logic                  vld;
    logic [PRIO_W-1:0]     prio;
    logic [LINE_NUM_W-1:0] idx;
  } cand_t;

  // controller to datapath
  typedef struct packed {
    logic item_ld;
    logic grp_ld;
    logic apply;
  } pic_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_ack;
  } pic_status_t;

  // left (lower index) wins unless right is valid and left is not or right is strictly more urgent
  function automatic cand_t cand_pick(cand_t a, cand_t b);
    cand_t w;
    if (b.vld && (!a.vld || (b.prio < a.prio))) begin
      w = b;
    end else begin
      w = a;
    end
    return w;
  endfunction

  // four-level reduction of one group of contenders
  function automatic cand_t cand_best(cand_t [GROUP_SIZE-1:0] c);
    cand_t [GROUP_SIZE-1:0] w;
    w = c;
    for (int s = 1; s < GROUP_SIZE; s = s * 2) begin
      for (int i = 0; i + s < GROUP_SIZE; i = i + 2 * s) begin
        w[i] = cand_pick(w[i], w[i+s]);
      end
    end
    return w[0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/pic_ctrl.sv -----
// ----------------------------------------------------------------------------
// pic_ctrl
// sequencer of the controller: takes a beat, steps the datapath, owns out_tvalid
// ----------------------------------------------------------------------------
`default_nettype none

module pic_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output pic_pkg::pic_cmd_t    cmd,
  input  pic_pkg::pic_status_t status
);
  import pic_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // state and output valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result register may be reloaded when empty or drained this cycle
  assign out_free = !out_valid_r || out_tready;

  // next state and datapath commands
  always_comb begin
    state_nxt   = state_r;
    in_tready   = 1'b0;
    cmd         = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.item_ld = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status.is_ack) begin
          cmd.grp_ld = 1'b1;
          state_nxt  = ST_FINAL;
        end else if (out_free) begin
          cmd.apply = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_FINAL: begin
        if (out_free) begin
          cmd.apply = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output valid: set on apply, cleared when the beat is taken
  always_comb begin
    if (cmd.apply) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

// ----- rtl/pic_datapath.sv -----
// ----------------------------------------------------------------------------
// pic_datapath
// per-line state, two-stage priority tree and result register
// ----------------------------------------------------------------------------
`default_nettype none

module pic_datapath #(
  parameter int NUM_LINES = pic_pkg::NUM_LINES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  pic_pkg::pic_cmd_t                cmd,
  output pic_pkg::pic_status_t             status,
  input  logic [pic_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic [pic_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import pic_pkg::*;

  localparam int LINE_W     = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
  localparam int NUM_GROUPS = (NUM_LINES + GROUP_SIZE - 1) / GROUP_SIZE;

  // held access
  opcode_t               op_r;
  logic [LINE_NUM_W-1:0] line_r;
  logic [PRIO_W-1:0]     pval_r;

  // per-line state
  logic [NUM_LINES-1:0]  enable_r;
  logic [NUM_LINES-1:0]  pending_r;
  logic [NUM_LINES-1:0]  active_r;
  logic [PRIO_W-1:0]     prio_r [NUM_LINES];

  // selection tree
  cand_t [NUM_GROUPS-1:0][GROUP_SIZE-1:0] leaf;
  cand_t [NUM_GROUPS-1:0]                 grp_nxt;
  cand_t [NUM_GROUPS-1:0]                 grp_r;
  cand_t [GROUP_SIZE-1:0]                 top_leaf;
  cand_t                                  win;
  logic [LINE_W-1:0]                      win_idx;

  // result register
  logic                 pend_out_r, pend_out_nxt;
  logic [PRIO_W-1:0]    prio_out_r, prio_out_nxt;
  logic                 gv_out_r, gv_out_nxt;
  logic [GRANT_W-1:0]   gl_out_r, gl_out_nxt;

  logic                 line_ok;
  logic [LINE_W-1:0]    line_idx;

  // capture the accepted beat
  always_ff @(posedge clk) begin
    if (cmd.item_ld) begin
      op_r   <= opcode_t'(in_tdata[OPCODE_W-1:0]);
      line_r <= in_tdata[OPCODE_W +: LINE_NUM_W];
      pval_r <= in_tdata[OPCODE_W+LINE_NUM_W +: PRIO_W];
    end
  end

  assign line_ok       = (line_r < LINE_NUM_W'(NUM_LINES));
  assign line_idx      = line_r[LINE_W-1:0];
  assign status.is_ack = (op_r == OP_ACK);

  // first stage: best enabled pending line of each group
  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      for (int j = 0; j < GROUP_SIZE; j++) begin
        if (g * GROUP_SIZE + j < NUM_LINES) begin
          leaf[g][j].vld  = enable_r[g*GROUP_SIZE+j] & pending_r[g*GROUP_SIZE+j];
          leaf[g][j].prio = prio_r[g*GROUP_SIZE+j];
          leaf[g][j].idx  = LINE_NUM_W'(g * GROUP_SIZE + j);
        end else begin
          leaf[g][j] = '0;
        end
      end
      grp_nxt[g] = cand_best(leaf[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.grp_ld) begin
      grp_r <= grp_nxt;
    end
  end

  // second stage: best of the group winners
  always_comb begin
    for (int k = 0; k < GROUP_SIZE; k++) begin
      if (k < NUM_GROUPS) begin
        top_leaf[k] = grp_r[k];
      end else begin
        top_leaf[k] = '0;
      end
    end
    win = cand_best(top_leaf);
  end

  assign win_idx = win.idx[LINE_W-1:0];

  // per-line state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r  <= '0;
      pending_r <= '0;
      active_r  <= '0;
      for (int i = 0; i < NUM_LINES; i++) begin
        prio_r[i] <= PRIO_MAX;
      end
    end else if (cmd.apply) begin
      unique case (op_r)
        OP_ENABLE:   if (line_ok) enable_r[line_idx]  <= 1'b1;
        OP_DISABLE:  if (line_ok) enable_r[line_idx]  <= 1'b0;
        OP_SET_PEND: if (line_ok) pending_r[line_idx] <= 1'b1;
        OP_CLR_PEND: if (line_ok) pending_r[line_idx] <= 1'b0;
        OP_SET_PRIO: if (line_ok) prio_r[line_idx]    <= pval_r;
        OP_ACK: begin
          if (win.vld) begin
            pending_r[win_idx] <= 1'b0;
            active_r[win_idx]  <= 1'b1;
          end
        end
        OP_END:      if (line_ok) active_r[line_idx]  <= 1'b0;
        default: begin
        end
      endcase
    end
  end

  // result fields, zero unless the access produces them
  always_comb begin
    pend_out_nxt = 1'b0;
    prio_out_nxt = '0;
    gv_out_nxt   = 1'b0;
    gl_out_nxt   = '0;
    unique case (op_r)
      OP_READ_PEND: pend_out_nxt = line_ok ? pending_r[line_idx] : 1'b0;
      OP_READ_PRIO: prio_out_nxt = line_ok ? prio_r[line_idx] : PRIO_MAX;
      OP_ACK: begin
        if (win.vld) begin
          gv_out_nxt = 1'b1;
          gl_out_nxt = GRANT_W'(win_idx);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      pend_out_r <= pend_out_nxt;
      prio_out_r <= prio_out_nxt;
      gv_out_r   <= gv_out_nxt;
      gl_out_r   <= gl_out_nxt;
    end
  end

  assign out_tdata = {{OUT_PAD_W{1'b0}}, gl_out_r, gv_out_r, prio_out_r, pend_out_r};

endmodule

`default_nettype wire

// ----- rtl/priority_interrupt_controller_core.sv -----
// ----------------------------------------------------------------------------
// priority_interrupt_controller_core
// interrupt controller with per-line enable, pending, active and priority
// ----------------------------------------------------------------------------
// Each input beat is one register access (enable, disable, set or clear
// pending, read pending, set or read priority, acknowledge, end of handler)
// and gives exactly one output beat. An access is first captured and then
// applied; acknowledge adds a step between them, as the priority tree is
// split into a group stage of 16 lines and a final stage over the group
// winners, with a register between them. A new beat is taken while an earlier
// result still waits on the output; the block then holds in its last step
// until that result is taken. All line state clears on reset, no clearing pass
// is needed.
`default_nettype none

module priority_interrupt_controller_core #(
  parameter int NUM_LINES = pic_pkg::NUM_LINES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // opcode[3:0], line_number[11:4], priority_value[15:12]
  input  logic [pic_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // pending_read[0], priority_read[4:1], grant_valid[5], granted_line[11:6],
  // zero padding[15:12]
  output logic [pic_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready
);
  import pic_pkg::*;

  pic_cmd_t    cmd;
  pic_status_t status;

  // sequencer
  pic_ctrl u_pic_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .status     (status)
  );

  // line state and selection
  pic_datapath #(
    .NUM_LINES (NUM_LINES)
  ) u_pic_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata)
  );

endmodule

`default_nettype wire

// ----- rtl/pic_checker.sv -----
// ----------------------------------------------------------------------------
// pic_checker
// port-level checks of the priority interrupt controller, bound to the top
// ----------------------------------------------------------------------------
`default_nettype none

`include "priority_interrupt_controller_core_defines.svh"

module pic_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // a stalled result beat stays offered
  `PIC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result beat dropped")

  // a stalled result beat keeps its payload
  `PIC_ASSERT_NEXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata), "result changed")

  // one access at a time: busy right after taking a beat
  `PIC_ASSERT_NEXT(a_busy, in_tvalid && in_tready, !in_tready, "beat taken while busy")

  // no result can appear in the cycle right after a beat is taken
  `PIC_ASSERT_NEXT(a_latency, in_tvalid && in_tready, !$rose(out_tvalid), "result too early")

  // no grant means a zero line number
  `PIC_ASSERT_SAME(a_no_grant, out_tvalid && !out_tdata[5], out_tdata[11:6] == 6'd0,
                   "line reported without grant")

endmodule

bind priority_interrupt_controller_core pic_checker u_pic_checker (.*);

`default_nettype wire
